// ----- design/cube_map_point_projection_defines.svh -----
// Assertion macros shared by the cube map projection RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef CUBE_MAP_POINT_PROJECTION_DEFINES_SVH
`define CUBE_MAP_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication
`define CMPP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cmpp: same-cycle check failed");

// Next-cycle implication
`define CMPP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cmpp: next-cycle check failed");

`endif

// ----- design/cmpp_pkg.sv -----
// Shared types, widths and helpers for the cube map projection pipeline.
// No dependencies.
`default_nettype none

package cmpp_pkg;

   localparam int COORD_W   = 32;
   localparam int MAG_W     = 31;
   localparam int MAP_W     = 17;
   localparam int SUM_W     = 35;   // signed width holding up to 8*m
   localparam int NUMER_W   = 34;   // unsigned un/vn, at most 8*m
   localparam int NUM_W     = 50;   // shifted dividend
   localparam int DIV_W     = 33;   // divisor and remainder
   localparam int QUO_W     = 18;   // quotient, twice the Q0.16 result
   localparam int DIV_STEPS = QUO_W;
   localparam int U_SHIFT   = 14;   // 2*65536/8
   localparam int V_SHIFT   = 16;   // 2*65536/6 over divisor 3m

   localparam logic [MAP_W-1:0] MAP_ONE = MAP_W'(65536);

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_word_type;

   typedef struct packed {
      logic [MAP_W-1:0] map_u;
      logic [MAP_W-1:0] map_v;
      logic [MAG_W-1:0] major_mag;
      logic             zero_point;
   } rsp_word_type;

   typedef enum logic [5:0] {
      FACE_PX = 6'b000001,
      FACE_PY = 6'b000010,
      FACE_PZ = 6'b000100,
      FACE_NX = 6'b001000,
      FACE_NY = 6'b010000,
      FACE_NZ = 6'b100000
   } face_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [MAG_W-1:0]          mag;
      face_type                  face;
      logic                      zero;
   } class_word_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] lq;    // dividend low bits shifting out, quotient in
      logic [DIV_W-1:0] dsr;
   } lane_type;

   typedef struct packed {
      lane_type         lane_u;
      lane_type         lane_v;
      logic [MAG_W-1:0] mag;
      logic             zero;
   } div_word_type;

   // Pull the most negative code in by one so the magnitude fits 31 bits
   function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] r;
      r = c;
      if (c == {1'b1, {(COORD_W-1){1'b0}}}) begin
         r = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
      end
      return r;
   endfunction

   function automatic logic [MAG_W-1:0] abs_coord(logic signed [COORD_W-1:0] c);
      logic [COORD_W-1:0] r;
      r = c[COORD_W-1] ? COORD_W'(-c) : COORD_W'(c);
      return r[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/cmpp_classify.sv -----
// Stage 1: saturate the point, take magnitudes and pick the major face.
// Uses cmpp_pkg and the assertion macros.
`default_nettype none
`include "cube_map_point_projection_defines.svh"

module cmpp_classify (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  cmpp_pkg::req_word_type   in_word,
   output logic                     out_valid,
   input  wire                      out_ready,
   output cmpp_pkg::class_word_type out_word
);
   import cmpp_pkg::*;

   logic                      valid_ff;
   class_word_type            word_ff;
   class_word_type            word_in;
   logic signed [COORD_W-1:0] sx, sy, sz;
   logic [MAG_W-1:0]          ax, ay, az;
   logic                      ge_xy, ge_xz, ge_yx, ge_yz, ge_zx, ge_zy;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Magnitude compares, all in parallel
   always_comb begin
      sx = sat_coord(in_word.coord_x);
      sy = sat_coord(in_word.coord_y);
      sz = sat_coord(in_word.coord_z);
      ax = abs_coord(sx);
      ay = abs_coord(sy);
      az = abs_coord(sz);
      ge_xy = ax >= ay;
      ge_xz = ax >= az;
      ge_yx = ay >= ax;
      ge_yz = ay >= az;
      ge_zx = az >= ax;
      ge_zy = az >= ay;
   end

   // Face priority +X, +Y, +Z, -X, -Y, else -Z
   always_comb begin
      word_in.x    = sx;
      word_in.y    = sy;
      word_in.z    = sz;
      word_in.zero = (sx == '0) && (sy == '0) && (sz == '0);
      if (!sx[COORD_W-1] && ge_xy && ge_xz) begin
         word_in.face = FACE_PX;
         word_in.mag  = ax;
      end else if (!sy[COORD_W-1] && ge_yx && ge_yz) begin
         word_in.face = FACE_PY;
         word_in.mag  = ay;
      end else if (!sz[COORD_W-1] && ge_zx && ge_zy) begin
         word_in.face = FACE_PZ;
         word_in.mag  = az;
      end else if (sx[COORD_W-1] && ge_xy && ge_xz) begin
         word_in.face = FACE_NX;
         word_in.mag  = ax;
      end else if (sy[COORD_W-1] && ge_yx && ge_yz) begin
         word_in.face = FACE_NY;
         word_in.mag  = ay;
      end else begin
         word_in.face = FACE_NZ;
         word_in.mag  = az;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   // A point off the origin always has a nonzero major axis
   `CMPP_ASSERT_NOW(a_mag_nonzero, valid_ff && !word_ff.zero, word_ff.mag != '0)

endmodule

`default_nettype wire

// ----- design/cmpp_numer.sv -----
// Stage 2: per-face numerators and divisors, loaded into the divider lanes.
// Uses cmpp_pkg.
`default_nettype none

module cmpp_numer (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  cmpp_pkg::class_word_type in_word,
   output logic                     out_valid,
   input  wire                      out_ready,
   output cmpp_pkg::div_word_type   out_word
);
   import cmpp_pkg::*;

   logic                    valid_ff;
   div_word_type            word_ff;
   div_word_type            word_in;
   logic signed [SUM_W-1:0] m1, m3, m5, m7, xe, ye, ze, un, vn;
   logic [NUM_W-1:0]        num_u, num_v;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Multiples of m and the signed minor coordinates
   always_comb begin
      m1 = SUM_W'({1'b0, in_word.mag});
      m3 = m1 + (m1 <<< 1);
      m5 = m1 + (m1 <<< 2);
      m7 = (m1 <<< 3) - m1;
      xe = SUM_W'(in_word.x);
      ye = SUM_W'(in_word.y);
      ze = SUM_W'(in_word.z);
   end

   // Face formulas; both numerators land in [0, 8m]
   always_comb begin
      case (in_word.face)
         FACE_PX: begin un = m5 - ze; vn = m3 + ye; end
         FACE_PY: begin un = m3 + xe; vn = m5 - ze; end
         FACE_PZ: begin un = m3 + xe; vn = m3 + ye; end
         FACE_NX: begin un = m1 + ze; vn = m3 + ye; end
         FACE_NY: begin un = m3 + xe; vn = m1 + ze; end
         FACE_NZ: begin un = m7 - xe; vn = m3 + ye; end
         default: begin un = m7 - xe; vn = m3 + ye; end
      endcase
   end

   // u: 2^14*un / m, v: 2^16*vn / 3m, each giving twice the Q0.16 result
   always_comb begin
      num_u = NUM_W'({un[NUMER_W-1:0], {U_SHIFT{1'b0}}});
      num_v = NUM_W'({vn[NUMER_W-1:0], {V_SHIFT{1'b0}}});
      word_in.lane_u.rem = DIV_W'(num_u[NUM_W-1:QUO_W]);
      word_in.lane_u.lq  = num_u[QUO_W-1:0];
      word_in.lane_u.dsr = DIV_W'(in_word.mag);
      word_in.lane_v.rem = DIV_W'(num_v[NUM_W-1:QUO_W]);
      word_in.lane_v.lq  = num_v[QUO_W-1:0];
      word_in.lane_v.dsr = m3[DIV_W-1:0];
      word_in.mag        = in_word.mag;
      word_in.zero       = in_word.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cmpp_div_step.sv -----
// One restoring division step for both lanes: one quotient bit per stage.
// Uses cmpp_pkg and the assertion macros.
`default_nettype none
`include "cube_map_point_projection_defines.svh"

module cmpp_div_step (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  cmpp_pkg::div_word_type in_word,
   output logic                   out_valid,
   input  wire                    out_ready,
   output cmpp_pkg::div_word_type out_word
);
   import cmpp_pkg::*;

   logic         valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   function automatic lane_type step_lane(lane_type l);
      logic [DIV_W:0] t;
      logic [DIV_W:0] d;
      logic [DIV_W:0] diff;
      logic           ge;
      lane_type       r;
      t    = {l.rem, l.lq[QUO_W-1]};
      d    = {1'b0, l.dsr};
      diff = t - d;
      ge   = t >= d;
      r.rem = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
      r.lq  = {l.lq[QUO_W-2:0], ge};
      r.dsr = l.dsr;
      return r;
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      word_in.lane_u = step_lane(in_word.lane_u);
      word_in.lane_v = step_lane(in_word.lane_v);
      word_in.mag    = in_word.mag;
      word_in.zero   = in_word.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   // Partial remainder stays below the divisor
   `CMPP_ASSERT_NOW(a_rem_below_dsr, valid_ff && !word_ff.zero,
                    (word_ff.lane_u.rem < word_ff.lane_u.dsr) &&
                    (word_ff.lane_v.rem < word_ff.lane_v.dsr))

endmodule

`default_nettype wire

// ----- design/cmpp_round.sv -----
// Last stage: round the doubled quotients to nearest and register the result.
// Uses cmpp_pkg and the assertion macros.
`default_nettype none
`include "cube_map_point_projection_defines.svh"

module cmpp_round (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  cmpp_pkg::div_word_type in_word,
   output logic                   out_valid,
   input  wire                    out_ready,
   output cmpp_pkg::rsp_word_type out_word
);
   import cmpp_pkg::*;

   logic             valid_ff;
   rsp_word_type     word_ff;
   rsp_word_type     word_in;
   logic [QUO_W-1:0] su, sv;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // (q + 1) / 2 gives round to nearest, ties up
   always_comb begin
      su = in_word.lane_u.lq + QUO_W'(1);
      sv = in_word.lane_v.lq + QUO_W'(1);
      word_in.zero_point = in_word.zero;
      if (in_word.zero) begin
         word_in.map_u     = '0;
         word_in.map_v     = '0;
         word_in.major_mag = '0;
      end else begin
         word_in.map_u     = su[QUO_W-1:1];
         word_in.map_v     = sv[QUO_W-1:1];
         word_in.major_mag = in_word.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   `CMPP_ASSERT_NOW(a_origin_zeroed, valid_ff && word_ff.zero_point,
                    (word_ff.map_u == '0) && (word_ff.map_v == '0) && (word_ff.major_mag == '0))
   `CMPP_ASSERT_NOW(a_map_in_range, valid_ff && !word_ff.zero_point,
                    (word_ff.map_u <= MAP_ONE) && (word_ff.map_v <= MAP_ONE))
   `CMPP_ASSERT_NEXT(a_held_when_stalled, valid_ff && !out_ready,
                     valid_ff && (word_ff == $past(word_ff)))

endmodule

`default_nettype wire

// ----- design/cube_map_point_projection.sv -----
// Top level of the cube map face projection pipeline.
// Uses cmpp_pkg, cmpp_classify, cmpp_numer, cmpp_div_step and cmpp_round.
`default_nettype none

// Projects a Q16.16 point onto the major-axis cube face and returns its
// horizontal-cross (u,v) in Q0.16, the major magnitude and an origin flag.
// One word is accepted per clock while req_stall is low; each result passes through
// one stage for face selection, one for the face numerators, 18 restoring
// division stages (one quotient bit each, u and v lanes side by side) and
// one rounding/output stage. Every stage holds a valid bit and moves on
// whenever the stage after it is empty or moving, so a stall on rsp fills
// empty stages before req_stall rises.
module cube_map_point_projection (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  cmpp_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output cmpp_pkg::rsp_word_type rsp_word
);
   import cmpp_pkg::*;

   logic           in_ready;
   logic           cls_valid;
   logic           cls_ready;
   class_word_type cls_word;
   logic           div_valid [0:DIV_STEPS];
   logic           div_ready [0:DIV_STEPS];
   div_word_type   div_word  [0:DIV_STEPS];

   assign req_stall = !in_ready;

   cmpp_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_word   (req_word),
      .out_valid (cls_valid),
      .out_ready (cls_ready),
      .out_word  (cls_word)
   );

   cmpp_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_word   (cls_word),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_word  (div_word[0])
   );

   // Divider chain, one quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cmpp_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_word   (div_word[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_word  (div_word[i+1])
      );
   end

   cmpp_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[DIV_STEPS]),
      .in_ready  (div_ready[DIV_STEPS]),
      .in_word   (div_word[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

`default_nettype wire
